[src/mp2d_pkg.sv]
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants and types for the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_KERNEL  = 8;
  localparam int MAX_RESULTS = 25;

  localparam int ST_ROW_BITS = $clog2(MAX_KERNEL);
  localparam int ST_COL_BITS = $clog2(MAX_WIDTH);
  localparam int ST_DEPTH    = MAX_KERNEL * MAX_WIDTH;
  localparam int ST_AW       = ST_ROW_BITS + ST_COL_BITS;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 8;   // row / column position inside a plane
  localparam int END_W    = 10;  // unclamped window end coordinate
  localparam int IDX_W    = 9;   // output row / column index
  localparam int CNT_W    = 5;   // results per request

  localparam logic signed [SAMPLE_W-1:0] FIXED_MIN = 16'sh8000;

  // Register indexes
  localparam logic [3:0] REG_HEIGHT      = 4'd0;
  localparam logic [3:0] REG_WIDTH       = 4'd1;
  localparam logic [3:0] REG_KERNEL_ROWS = 4'd2;
  localparam logic [3:0] REG_KERNEL_COLS = 4'd3;
  localparam logic [3:0] REG_STRIDE_ROWS = 4'd4;
  localparam logic [3:0] REG_STRIDE_COLS = 4'd5;
  localparam logic [3:0] REG_PAD_ROWS    = 4'd6;
  localparam logic [3:0] REG_PAD_COLS    = 4'd7;

  // Clamped settings handed from the register file to the sequencer
  typedef struct packed {
    logic [8:0] h;     // 1..256
    logic [8:0] w;     // 1..256
    logic [7:0] h_m1;
    logic [7:0] w_m1;
    logic [3:0] kr;    // 1..8
    logic [3:0] kc;
    logic [3:0] sr;    // 1..15
    logic [3:0] sc;
    logic [2:0] pr;    // 0..kr/2
    logic [2:0] pc;
  } mp2d_cfg_t;

endpackage

[src/mp2d_ram.sv]
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mp2d_cfg.sv]
// ----------------------------------------------------------------------------
// mp2d_cfg
// Configuration register file with saturation of each setting.
// ----------------------------------------------------------------------------
module mp2d_cfg
  import mp2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [8:0] cfg_data,
  output mp2d_cfg_t  cfg
);

  logic [8:0] height_r, width_r;
  logic [3:0] kr_r, kc_r, sr_r, sc_r;
  logic [2:0] pr_r, pc_r;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= 9'd16;
      width_r  <= 9'd16;
      kr_r     <= 4'd2;
      kc_r     <= 4'd2;
      sr_r     <= 4'd2;
      sc_r     <= 4'd2;
      pr_r     <= 3'd0;
      pc_r     <= 3'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEIGHT:      height_r <= cfg_data;
        REG_WIDTH:       width_r  <= cfg_data;
        REG_KERNEL_ROWS: kr_r     <= cfg_data[3:0];
        REG_KERNEL_COLS: kc_r     <= cfg_data[3:0];
        REG_STRIDE_ROWS: sr_r     <= cfg_data[3:0];
        REG_STRIDE_COLS: sc_r     <= cfg_data[3:0];
        REG_PAD_ROWS:    pr_r     <= cfg_data[2:0];
        REG_PAD_COLS:    pc_r     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Saturation
  logic [3:0] kr_c, kc_c;

  always_comb begin
    cfg.h = (height_r == 9'd0) ? 9'd1 :
            (height_r > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_r;
    cfg.w = (width_r == 9'd0) ? 9'd1 :
            (width_r > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_r;
    cfg.h_m1 = 8'(cfg.h - 9'd1);
    cfg.w_m1 = 8'(cfg.w - 9'd1);
    kr_c = (kr_r == 4'd0) ? 4'd1 : (kr_r > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kr_r;
    kc_c = (kc_r == 4'd0) ? 4'd1 : (kc_r > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kc_r;
    cfg.kr = kr_c;
    cfg.kc = kc_c;
    cfg.sr = (sr_r == 4'd0) ? 4'd1 : sr_r;
    cfg.sc = (sc_r == 4'd0) ? 4'd1 : sc_r;
    cfg.pr = ({1'b0, pr_r} > (kr_c >> 1)) ? 3'(kr_c >> 1) : pr_r;
    cfg.pc = ({1'b0, pc_r} > (kc_c >> 1)) ? 3'(kc_c >> 1) : pc_r;
  end

endmodule

[src/mp2d_seq.sv]
// ----------------------------------------------------------------------------
// mp2d_seq
// Window sequencer: tracks position and pending windows, scans each window
// through the line store with one shared compare unit, drives the result.
// ----------------------------------------------------------------------------
module mp2d_seq
  import mp2d_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mp2d_cfg_t                  cfg,
  // request side
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_W-1:0]        in_sample,
  input  logic                       in_start,
  // line store
  output logic                       st_we,
  output logic [ST_AW-1:0]           st_waddr,
  output logic [SAMPLE_W-1:0]        st_wdata,
  output logic [ST_AW-1:0]           st_raddr,
  input  logic [SAMPLE_W-1:0]        st_rdata,
  // result side
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SAMPLE_W-1:0]        out_max,
  output logic [IDX_W-1:0]           out_oh,
  output logic [IDX_W-1:0]           out_ow,
  output logic                       out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]                state_r;
  logic [POS_W-1:0]          row_pos_r, col_pos_r;
  logic [IDX_W-1:0]          oh_cur_r, ow_cur_r;
  logic [END_W-1:0]          rend_cur_r, cend_cur_r;
  logic [POS_W-1:0]          r_r, c_r;
  logic [IDX_W-1:0]          oh_it_r, ow_it_r, ow_first_r;
  logic [END_W-1:0]          rend_it_r, cend_it_r, cend_first_r;
  logic [CNT_W-1:0]          n_r;
  logic [POS_W-1:0]          i_r, j_r, j_lo_r, i_hi_r, j_hi_r;
  logic                      last_r;
  logic signed [SAMPLE_W-1:0] best_r;
  logic                      out_valid_r, out_last_r;
  logic [SAMPLE_W-1:0]       out_max_r;
  logic [IDX_W-1:0]          out_oh_r, out_ow_r;

  // Window end hit tests: exact end, or clamped onto the last row / column
  function automatic logic end_hit(input logic [END_W-1:0] e, input logic [POS_W-1:0] p,
                                   input logic [POS_W-1:0] p_last, input logic [2:0] pad);
    end_hit = (e == END_W'(p)) ||
              ((p == p_last) && (e <= END_W'(p_last) + END_W'(pad)));
  endfunction

  // Window start (clamped at zero) from its unclamped end
  function automatic logic [POS_W-1:0] win_lo(input logic [END_W-1:0] e,
                                              input logic [3:0] k);
    win_lo = (e + END_W'(1) >= END_W'(k)) ? POS_W'(e + END_W'(1) - END_W'(k)) : '0;
  endfunction

  function automatic logic [POS_W-1:0] win_hi(input logic [END_W-1:0] e,
                                              input logic [POS_W-1:0] p_last);
    win_hi = (e > END_W'(p_last)) ? p_last : POS_W'(e);
  endfunction

  // Position of an arriving sample
  logic             pos_bad, accept;
  logic [POS_W-1:0] r_eff, c_eff;
  logic [END_W-1:0] rinit, cinit, rfirst, cfirst;
  logic [IDX_W-1:0] ohfirst, owfirst;

  assign accept  = in_valid && (state_r == S_IDLE);
  assign pos_bad = in_start || ({1'b0, row_pos_r} >= cfg.h) || ({1'b0, col_pos_r} >= cfg.w);
  assign r_eff   = pos_bad ? '0 : row_pos_r;
  assign c_eff   = pos_bad ? '0 : col_pos_r;
  assign rinit   = END_W'(cfg.kr) - END_W'(1) - END_W'(cfg.pr);
  assign cinit   = END_W'(cfg.kc) - END_W'(1) - END_W'(cfg.pc);
  assign rfirst  = (r_eff == '0 && c_eff == '0) ? rinit : rend_cur_r;
  assign ohfirst = (r_eff == '0 && c_eff == '0) ? '0 : oh_cur_r;
  assign cfirst  = (c_eff == '0) ? cinit : cend_cur_r;
  assign owfirst = (c_eff == '0) ? '0 : ow_cur_r;

  assign in_ready = (state_r == S_IDLE);
  assign st_we    = accept;
  assign st_waddr = {r_eff[ST_ROW_BITS-1:0], c_eff[ST_COL_BITS-1:0]};
  assign st_wdata = in_sample;
  assign st_raddr = {i_r[ST_ROW_BITS-1:0], j_r[ST_COL_BITS-1:0]};

  // Next-window tests while emitting
  logic [END_W-1:0] cnext, rnext;
  logic             cn_hit, rn_hit, win_last, can_load;

  assign cnext    = cend_it_r + END_W'(cfg.sc);
  assign rnext    = rend_it_r + END_W'(cfg.sr);
  assign cn_hit   = end_hit(cnext, c_r, cfg.w_m1, cfg.pc);
  assign rn_hit   = end_hit(rnext, r_r, cfg.h_m1, cfg.pr);
  assign win_last = (n_r == CNT_W'(MAX_RESULTS - 1)) || (!cn_hit && !rn_hit);
  assign can_load = !out_valid_r || out_ready;

  logic signed [SAMPLE_W-1:0] rd_s;
  assign rd_s = st_rdata;

  // Result valid: set on a load, cleared once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && can_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      oh_cur_r    <= '0;
      ow_cur_r    <= '0;
      rend_cur_r  <= '0;
      cend_cur_r  <= '0;
    end else begin
      unique case (state_r) inside
        S_IDLE: begin
          if (accept) begin
            r_r          <= r_eff;
            c_r          <= c_eff;
            oh_it_r      <= ohfirst;
            rend_it_r    <= rfirst;
            ow_it_r      <= owfirst;
            cend_it_r    <= cfirst;
            ow_first_r   <= owfirst;
            cend_first_r <= cfirst;
            n_r          <= '0;
            // column window tracking within the row
            if (c_eff != cfg.w_m1 && cfirst == END_W'(c_eff)) begin
              ow_cur_r   <= owfirst + IDX_W'(1);
              cend_cur_r <= cfirst + END_W'(cfg.sc);
            end else begin
              ow_cur_r   <= owfirst;
              cend_cur_r <= cfirst;
            end
            // row window tracking, advanced at the end of a row
            if (c_eff == cfg.w_m1 && r_eff != cfg.h_m1 && rfirst == END_W'(r_eff)) begin
              oh_cur_r   <= ohfirst + IDX_W'(1);
              rend_cur_r <= rfirst + END_W'(cfg.sr);
            end else begin
              oh_cur_r   <= ohfirst;
              rend_cur_r <= rfirst;
            end
            // raster position of the next sample
            if (c_eff == cfg.w_m1) begin
              col_pos_r <= '0;
              row_pos_r <= (r_eff == cfg.h_m1) ? '0 : r_eff + POS_W'(1);
            end else begin
              col_pos_r <= c_eff + POS_W'(1);
              row_pos_r <= r_eff;
            end
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (n_r == CNT_W'(MAX_RESULTS) ||
              !end_hit(rend_it_r, r_r, cfg.h_m1, cfg.pr) ||
              !end_hit(cend_it_r, c_r, cfg.w_m1, cfg.pc)) begin
            state_r <= S_IDLE;
          end else begin
            i_r     <= win_lo(rend_it_r, cfg.kr);
            i_hi_r  <= win_hi(rend_it_r, cfg.h_m1);
            j_r     <= win_lo(cend_it_r, cfg.kc);
            j_lo_r  <= win_lo(cend_it_r, cfg.kc);
            j_hi_r  <= win_hi(cend_it_r, cfg.w_m1);
            best_r  <= FIXED_MIN;
            state_r <= S_READ;
          end
        end
        S_READ, S_ACC: begin
          if (state_r == S_ACC && rd_s > best_r) begin
            best_r <= rd_s;
          end
          if (state_r == S_ACC && last_r) begin
            state_r <= S_EMIT;
          end else begin
            // issue the read at (i, j) and step the scan
            last_r <= (j_r == j_hi_r) && (i_r == i_hi_r);
            if (j_r == j_hi_r) begin
              j_r <= j_lo_r;
              i_r <= i_r + POS_W'(1);
            end else begin
              j_r <= j_r + POS_W'(1);
            end
            state_r <= S_ACC;
          end
        end
        S_EMIT: begin
          if (can_load) begin
            out_max_r   <= best_r;
            out_oh_r    <= oh_it_r;
            out_ow_r    <= ow_it_r;
            out_last_r  <= win_last;
            n_r         <= n_r + CNT_W'(1);
            if (win_last) begin
              state_r <= S_IDLE;
            end else if (cn_hit) begin
              ow_it_r   <= ow_it_r + IDX_W'(1);
              cend_it_r <= cnext;
              state_r   <= S_CHECK;
            end else begin
              oh_it_r   <= oh_it_r + IDX_W'(1);
              rend_it_r <= rnext;
              ow_it_r   <= ow_first_r;
              cend_it_r <= cend_first_r;
              state_r   <= S_CHECK;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_max   = out_max_r;
  assign out_oh    = out_oh_r;
  assign out_ow    = out_ow_r;
  assign out_last  = out_last_r;

endmodule

[src/max_pool_2d_stream_top.sv]
// Timing: a sample that closes no window passes through CHECK and back to IDLE;
//   a sample that closes windows runs CHECK, READ, one ACC per element of each
//   window's in-bounds part (one line-store read each) and EMIT per window,
//   and EMIT waits while the result is held. A new sample is taken only in
//   IDLE; the single read port and the one compare unit serialize the scan.
// Reset: rst_n synchronous, active low; clears settings to defaults, position
//   and result valid. The line store is not cleared.
// ----------------------------------------------------------------------------
// max_pool_2d_stream_top
// Streaming 2-D max pooling over raster-order image planes.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_top
  import mp2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [0:0]  in_tuser,   // [0] plane_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] max_value, [24:16] out_row, [33:25] out_col
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  mp2d_cfg_t           cfg;
  logic                st_we;
  logic [ST_AW-1:0]    st_waddr, st_raddr;
  logic [SAMPLE_W-1:0] st_wdata, st_rdata;
  logic [SAMPLE_W-1:0] res_max;
  logic [IDX_W-1:0]    res_oh, res_ow;

  mp2d_cfg u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  mp2d_ram #(.WIDTH(SAMPLE_W), .DEPTH(ST_DEPTH)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  mp2d_seq u_seq (
    .clk, .rst_n, .cfg,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_sample(in_tdata), .in_start(in_tuser[0]),
    .st_we, .st_waddr, .st_wdata, .st_raddr, .st_rdata,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_max(res_max), .out_oh(res_oh), .out_ow(res_ow), .out_last(out_tlast)
  );

  assign out_tdata = {6'd0, res_ow, res_oh, res_max};

endmodule

[src/mp2d_chk.sv]
// ----------------------------------------------------------------------------
// mp2d_chk
// Port-level checks on the max pooling top level, bound to it.
// ----------------------------------------------------------------------------
module mp2d_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // no result without a request in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result without request");

  // reset empties the result stage
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind max_pool_2d_stream_top mp2d_chk u_chk (.*);
